// File: hw/rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

   // Field widths of the transaction payloads
   localparam int OPCODE_W = 2;
   localparam int IDX_W    = 3;
   localparam int ELEM_W   = 16;
   localparam int RESULT_W = 32;
   localparam int ACC_W    = 40;
   localparam int DIM_W    = 4;
   localparam int CSR_IDX_W = 2;

   // Command opcodes
   localparam logic [OPCODE_W-1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COMPUTE    = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COLS = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   // Saturation limits of the Q16.16 result
   localparam logic signed [RESULT_W-1:0] RESULT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [RESULT_W-1:0] RESULT_MIN = 32'sh8000_0000;

   // Input transaction
   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic [IDX_W-1:0]         elem_row;
      logic [IDX_W-1:0]         elem_col;
      logic signed [ELEM_W-1:0] elem_value;
   } mme_req_type;

   // Result transaction
   typedef struct packed {
      logic [IDX_W-1:0]           out_row;
      logic [IDX_W-1:0]           out_col;
      logic signed [RESULT_W-1:0] out_value;
      logic                       out_last;
   } mme_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic             load_left;
      logic             load_right;
      logic             issue;
      logic [DIM_W-1:0] r;
      logic [DIM_W-1:0] c;
      logic [DIM_W-1:0] l;
      logic             first;
      logic             last_k;
      logic             last;
   } mme_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic pipe_busy;
   } mme_status_type;

   // Tag that travels with a product through the pipeline
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             first;
      logic             last_k;
      logic             last;
   } mme_tag_type;

endpackage

// File: hw/rtl/matrix_multiply_engine_core.sv
// Top level of the fixed-point dense matrix multiply engine.
`timescale 1ns / 1ps
//
//   channel   handshake            payload                 direction
//   req       start, busy          req_data (mme_req_type)  in
//   rsp       rsp_strobe           rsp_data (mme_rsp_type)  out
//   csr       csr_we               csr_index, csr_wdata     in
//
// A load transaction leaves busy low, so the next one can follow.
// A compute transaction (m rows, n columns, k inner terms, clamped) holds busy
// until its last result is shown: the single multiply-accumulate unit takes one
// inner term per cycle, behind a registered store read and a product register.
// Reset is synchronous; configuration registers reset to 8, stores are not cleared.
// Results carry no back-pressure: each is on rsp_data for the one cycle of rsp_strobe.

module matrix_multiply_engine_core #(
   parameter int MAX_DIM   = 8,
   parameter int ELEM_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mme_pkg::mme_req_type           req_data,
   output logic                           rsp_strobe,
   output mme_pkg::mme_rsp_type           rsp_data,
   input  logic                           csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mme_pkg::DIM_W-1:0]      csr_wdata
);

   mme_pkg::mme_cmd_type     cmd;
   mme_pkg::mme_status_type  status;

   // Sequencer and configuration
   mme_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_data.opcode),
      .busy      (busy),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   // Stores and multiply-accumulate
   mme_datapath #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: hw/rtl/mme_ctrl.sv
// Controller: configuration registers, command decode and loop sequencer.
`timescale 1ns / 1ps

module mme_ctrl #(
   parameter int MAX_DIM = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mme_pkg::OPCODE_W-1:0]      opcode,
   output logic                              busy,
   input  logic                              csr_we,
   input  logic [mme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mme_pkg::DIM_W-1:0]         csr_wdata,
   output mme_pkg::mme_cmd_type              cmd,
   input  mme_pkg::mme_status_type           status
);

   localparam int DIM_LIM = (MAX_DIM > 15) ? 15 : MAX_DIM;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(
      input logic [mme_pkg::DIM_W-1:0] v
   );
      logic [mme_pkg::DIM_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = mme_pkg::DIM_W'(1);
      end else if (32'(v) > DIM_LIM) begin
         res = mme_pkg::DIM_W'(DIM_LIM);
      end
      return res;
   endfunction

   state_type                  state_ff, state_in;
   logic [mme_pkg::DIM_W-1:0]  rows_ff, rows_in;
   logic [mme_pkg::DIM_W-1:0]  inner_ff, inner_in;
   logic [mme_pkg::DIM_W-1:0]  cols_ff, cols_in;
   logic [mme_pkg::DIM_W-1:0]  r_ff, r_in;
   logic [mme_pkg::DIM_W-1:0]  c_ff, c_in;
   logic [mme_pkg::DIM_W-1:0]  l_ff, l_in;
   logic [mme_pkg::DIM_W-1:0]  m_dim, k_dim, n_dim;
   logic                       accept;
   logic                       last_l, last_c, last_r;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign m_dim = clamp_dim(rows_ff);
   assign k_dim = clamp_dim(inner_ff);
   assign n_dim = clamp_dim(cols_ff);

   assign last_l = (l_ff == k_dim - 1'b1);
   assign last_c = (c_ff == n_dim - 1'b1);
   assign last_r = (r_ff == m_dim - 1'b1);

   // Configuration writes
   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_we) begin
         case (csr_index)
            mme_pkg::CSR_LEFT_ROWS:  rows_in  = csr_wdata;
            mme_pkg::CSR_INNER_SIZE: inner_in = csr_wdata;
            mme_pkg::CSR_RIGHT_COLS: cols_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: row-major over results, inner index fastest
   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      l_in     = l_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && opcode == mme_pkg::OP_COMPUTE) begin
               r_in     = '0;
               c_in     = '0;
               l_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_l) begin
               l_in = '0;
               if (last_c) begin
                  c_in = '0;
                  if (last_r) begin
                     state_in = ST_DRAIN;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               l_in = l_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd.load_left  = accept && (opcode == mme_pkg::OP_LOAD_LEFT);
      cmd.load_right = accept && (opcode == mme_pkg::OP_LOAD_RIGHT);
      cmd.issue      = (state_ff == ST_RUN);
      cmd.r          = r_ff;
      cmd.c          = c_ff;
      cmd.l          = l_ff;
      cmd.first      = (l_ff == '0);
      cmd.last_k     = last_l;
      cmd.last       = last_r && last_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= mme_pkg::DIM_RESET;
         inner_ff <= mme_pkg::DIM_RESET;
         cols_ff  <= mme_pkg::DIM_RESET;
         r_ff     <= '0;
         c_ff     <= '0;
         l_ff     <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         l_ff     <= l_in;
      end
   end

   // A compute transaction taken in idle starts the sequencer
   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == mme_pkg::OP_COMPUTE) |=> (state_ff == ST_RUN))
      else $error("compute transaction did not start the sequencer");

   // Loop counters stay inside the clamped dimensions while issuing
   a_counters_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (l_ff < k_dim && c_ff < n_dim && r_ff < m_dim))
      else $error("loop counter out of range");

   // No store write may happen while a compute is in flight
   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(cmd.load_left || cmd.load_right))
      else $error("store write while busy");

endmodule

// File: hw/rtl/mme_datapath.sv
// Datapath: element stores, multiply-accumulate pipeline and result register.
`timescale 1ns / 1ps

module mme_datapath #(
   parameter int MAX_DIM   = 8,
   parameter int ELEM_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mme_pkg::mme_req_type     req_data,
   input  mme_pkg::mme_cmd_type     cmd,
   output mme_pkg::mme_status_type  status,
   output logic                     rsp_strobe,
   output mme_pkg::mme_rsp_type     rsp_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW     = (ELEM_BITS < mme_pkg::ELEM_W) ? ELEM_BITS : mme_pkg::ELEM_W;

   logic [EW-1:0]                          left_mem  [DEPTH];
   logic [EW-1:0]                          right_mem [DEPTH];

   logic [15:0]                            wr_idx, a_idx, b_idx;
   logic [ADDR_W-1:0]                      wr_addr, a_addr, b_addr;
   logic                                   load_ok;
   logic [EW-1:0]                          wr_elem;

   logic [EW-1:0]                          a_rd_ff, b_rd_ff;
   logic signed [mme_pkg::ELEM_W-1:0]      a_ext, b_ext;
   logic                                   v1_ff, v2_ff, v3_ff;
   mme_pkg::mme_tag_type                   tag0, tag1_ff, tag2_ff, tag3_ff;
   logic signed [2*mme_pkg::ELEM_W-1:0]    prod_ff;
   logic signed [mme_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic signed [mme_pkg::RESULT_W-1:0]    sat_value;
   logic                                   out_valid_ff;
   mme_pkg::mme_rsp_type                   out_ff, out_in;

   // Store addressing: row-major, MAX_DIM entries per row
   assign wr_idx  = 16'(req_data.elem_row) * 16'(MAX_DIM) + 16'(req_data.elem_col);
   assign a_idx   = 16'(cmd.r) * 16'(MAX_DIM) + 16'(cmd.l);
   assign b_idx   = 16'(cmd.l) * 16'(MAX_DIM) + 16'(cmd.c);
   assign wr_addr = wr_idx[ADDR_W-1:0];
   assign a_addr  = a_idx[ADDR_W-1:0];
   assign b_addr  = b_idx[ADDR_W-1:0];
   assign load_ok = (32'(req_data.elem_row) < MAX_DIM) && (32'(req_data.elem_col) < MAX_DIM);
   assign wr_elem = req_data.elem_value[EW-1:0];

   // Left store
   always_ff @(posedge clock) begin
      if (cmd.load_left && load_ok) begin
         left_mem[wr_addr] <= wr_elem;
      end
      if (cmd.issue) begin
         a_rd_ff <= left_mem[a_addr];
      end
   end

   // Right store
   always_ff @(posedge clock) begin
      if (cmd.load_right && load_ok) begin
         right_mem[wr_addr] <= wr_elem;
      end
      if (cmd.issue) begin
         b_rd_ff <= right_mem[b_addr];
      end
   end

   // Tag for the element pair being read
   always_comb begin
      tag0.row    = cmd.r[mme_pkg::IDX_W-1:0];
      tag0.col    = cmd.c[mme_pkg::IDX_W-1:0];
      tag0.first  = cmd.first;
      tag0.last_k = cmd.last_k;
      tag0.last   = cmd.last;
   end

   assign a_ext = mme_pkg::ELEM_W'($signed(a_rd_ff));
   assign b_ext = mme_pkg::ELEM_W'($signed(b_rd_ff));

   // Accumulate: restart on the first inner term
   assign acc_in = tag2_ff.first ? mme_pkg::ACC_W'(prod_ff)
                                 : acc_ff + mme_pkg::ACC_W'(prod_ff);

   // Saturate to Q16.16
   always_comb begin
      sat_value = acc_ff[mme_pkg::RESULT_W-1:0];
      if (acc_ff > mme_pkg::ACC_W'(mme_pkg::RESULT_MAX)) begin
         sat_value = mme_pkg::RESULT_MAX;
      end else if (acc_ff < mme_pkg::ACC_W'(mme_pkg::RESULT_MIN)) begin
         sat_value = mme_pkg::RESULT_MIN;
      end
   end

   always_comb begin
      out_in.out_row   = tag3_ff.row;
      out_in.out_col   = tag3_ff.col;
      out_in.out_value = sat_value;
      out_in.out_last  = tag3_ff.last;
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff && tag3_ff.last_k;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      tag1_ff <= tag0;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      prod_ff <= a_ext * b_ext;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      if (v3_ff && tag3_ff.last_k) begin
         out_ff <= out_in;
      end
   end

   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || out_valid_ff;
   assign rsp_strobe       = out_valid_ff;
   assign rsp_data         = out_ff;

   // A result is only shown after the final inner term reached the accumulator
   a_result_after_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(v3_ff && tag3_ff.last_k))
      else $error("result strobe without a finished sum");

   // Every issued read passes through v1_ff and v2_ff on to the v3_ff stage
   a_pipe_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |=> ##2 v3_ff)
      else $error("issued read lost in the pipeline");

   // The pipeline reports busy while any stage holds a product
   a_busy_covers_pipe: assert property (@(posedge clock) disable iff (reset)
      (v1_ff || v2_ff || v3_ff) |-> status.pipe_busy)
      else $error("pipeline busy not reported");

endmodule

// File: sim/matrix_multiply_engine_core_tb.sv
// Self-checking testbench for the fixed-point matrix multiply engine.
`timescale 1ns / 1ps

module matrix_multiply_engine_core_tb;

   localparam int DIM    = 8;
   localparam int CELLS  = DIM * DIM;
   localparam int CELL_W = $clog2(CELLS);

   // Opcode that the engine must ignore
   localparam logic [mme_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          start     = 1'b0;
   logic                          csr_we    = 1'b0;
   logic [mme_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mme_pkg::DIM_W-1:0]     csr_wdata = '0;
   mme_pkg::mme_req_type          req_data  = '0;
   logic                          busy;
   logic                          rsp_strobe;
   mme_pkg::mme_rsp_type          rsp_data;

   matrix_multiply_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the engine: element stores and dimension registers
   logic signed [mme_pkg::ELEM_W-1:0] left_elems  [CELLS];
   logic signed [mme_pkg::ELEM_W-1:0] right_elems [CELLS];
   logic [mme_pkg::DIM_W-1:0]         rows_cfg  = mme_pkg::DIM_RESET;
   logic [mme_pkg::DIM_W-1:0]         inner_cfg = mme_pkg::DIM_RESET;
   logic [mme_pkg::DIM_W-1:0]         cols_cfg  = mme_pkg::DIM_RESET;

   // Entries already loaded by queued commands; compute needs its operands written
   bit left_loaded  [CELLS];
   bit right_loaded [CELLS];

   mme_pkg::mme_req_type pending_cmds[$];
   mme_pkg::mme_rsp_type expected_elems[$];
   mme_pkg::mme_rsp_type oldest_elem;

   int idle_pct      = 0;
   int planned       = 0;
   int cmds_accepted = 0;
   int computes_run  = 0;
   int elems_checked = 0;
   int errors        = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Dimension as the engine uses it: zero acts as one, above DIM acts as DIM
   function automatic int eff_dim(logic [mme_pkg::DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
   endfunction

   // Apply one accepted command to the shadow state; compute queues its products
   task automatic predict_products(mme_pkg::mme_req_type cmd);
      int                   m, k, n, r, c, l;
      longint               acc;
      mme_pkg::mme_rsp_type elem;
      case (cmd.opcode)
         mme_pkg::OP_LOAD_LEFT:
            left_elems[{cmd.elem_row, cmd.elem_col}] = cmd.elem_value;
         mme_pkg::OP_LOAD_RIGHT:
            right_elems[{cmd.elem_row, cmd.elem_col}] = cmd.elem_value;
         mme_pkg::OP_COMPUTE: begin
            computes_run++;
            m = eff_dim(rows_cfg);
            k = eff_dim(inner_cfg);
            n = eff_dim(cols_cfg);
            for (r = 0; r < m; r++) begin
               for (c = 0; c < n; c++) begin
                  acc = 0;
                  for (l = 0; l < k; l++) begin
                     acc += longint'(left_elems[CELL_W'(r * DIM + l)]) *
                            longint'(right_elems[CELL_W'(l * DIM + c)]);
                  end
                  elem.out_row = mme_pkg::IDX_W'(r);
                  elem.out_col = mme_pkg::IDX_W'(c);
                  if (acc > longint'(mme_pkg::RESULT_MAX))
                     elem.out_value = mme_pkg::RESULT_MAX;
                  else if (acc < longint'(mme_pkg::RESULT_MIN))
                     elem.out_value = mme_pkg::RESULT_MIN;
                  else
                     elem.out_value = mme_pkg::RESULT_W'(acc);
                  elem.out_last = (r == m - 1) && (c == n - 1);
                  expected_elems.push_back(elem);
               end
            end
         end
         default: ;  // unused opcode: no effect
      endcase
   endtask

   // Driver: present queued commands, with random gaps between transactions
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_products(req_data);
            cmds_accepted++;
         end
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= pending_cmds.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic flag_error(string what, mme_pkg::mme_rsp_type want,
                             mme_pkg::mme_rsp_type got);
      if (errors < 10) begin
         $display("%0t %s: expected row %0d col %0d value %0d last %0b",
                  $time, what, want.out_row, want.out_col, want.out_value, want.out_last);
         $display("   got row %0d col %0d value %0d last %0b",
                  got.out_row, got.out_col, got.out_value, got.out_last);
      end
      errors++;
   endtask

   // Monitor: every strobed result is checked against the oldest expected product
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         elems_checked++;
         if (expected_elems.size() == 0) begin
            flag_error("unexpected result", '0, rsp_data);
         end else begin
            oldest_elem = expected_elems.pop_front();
            if (rsp_data.out_row   !== oldest_elem.out_row   ||
                rsp_data.out_col   !== oldest_elem.out_col   ||
                rsp_data.out_value !== oldest_elem.out_value ||
                rsp_data.out_last  !== oldest_elem.out_last) begin
               flag_error("result mismatch", oldest_elem, rsp_data);
            end
         end
      end
   end

   // Element values lean toward the Q8.8 extremes
   function automatic logic [mme_pkg::ELEM_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return '0;
         default: return mme_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   task automatic queue_item(logic [mme_pkg::OPCODE_W-1:0] op, int row, int col,
                             logic [mme_pkg::ELEM_W-1:0] value);
      mme_pkg::mme_req_type cmd;
      cmd.opcode     = op;
      cmd.elem_row   = mme_pkg::IDX_W'(row);
      cmd.elem_col   = mme_pkg::IDX_W'(col);
      cmd.elem_value = value;
      pending_cmds.push_back(cmd);
      if (op == mme_pkg::OP_LOAD_LEFT) left_loaded[CELL_W'(row * DIM + col)] = 1'b1;
      if (op == mme_pkg::OP_LOAD_RIGHT) right_loaded[CELL_W'(row * DIM + col)] = 1'b1;
      if (op != OP_UNUSED) planned++;
   endtask

   // Compute transaction, preceded by loads of any operand not yet written
   task automatic queue_compute();
      int m, k, n, r, c, l;
      m = eff_dim(rows_cfg);
      k = eff_dim(inner_cfg);
      n = eff_dim(cols_cfg);
      for (r = 0; r < m; r++)
         for (l = 0; l < k; l++)
            if (!left_loaded[CELL_W'(r * DIM + l)])
               queue_item(mme_pkg::OP_LOAD_LEFT, r, l, pick_value());
      for (l = 0; l < k; l++)
         for (c = 0; c < n; c++)
            if (!right_loaded[CELL_W'(l * DIM + c)])
               queue_item(mme_pkg::OP_LOAD_RIGHT, l, c, pick_value());
      queue_item(mme_pkg::OP_COMPUTE, $urandom_range(7), $urandom_range(7),
                 mme_pkg::ELEM_W'($urandom));
   endtask

   task automatic write_csr(logic [mme_pkg::CSR_IDX_W-1:0] idx,
                            logic [mme_pkg::DIM_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   // Dimension writes happen only while the engine is idle
   task automatic set_dims(logic [mme_pkg::DIM_W-1:0] m, logic [mme_pkg::DIM_W-1:0] k,
                           logic [mme_pkg::DIM_W-1:0] n);
      write_csr(mme_pkg::CSR_LEFT_ROWS, m);
      write_csr(mme_pkg::CSR_INNER_SIZE, k);
      write_csr(mme_pkg::CSR_RIGHT_COLS, n);
      @(posedge clock);
      csr_we    <= 1'b0;
      rows_cfg  = m;
      inner_cfg = k;
      cols_cfg  = n;
   endtask

   // Wait until every command is accepted and every product has come back
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || start || busy || expected_elems.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   // Mostly well-formed load/compute runs, plus stray loads and unused opcodes
   task automatic run_phase(logic [mme_pkg::DIM_W-1:0] m, logic [mme_pkg::DIM_W-1:0] k,
                            logic [mme_pkg::DIM_W-1:0] n, int idle, int target);
      int choice, mm, kk, nn;
      set_dims(m, k, n);
      idle_pct = idle;
      planned  = 0;
      mm = eff_dim(m);
      kk = eff_dim(k);
      nn = eff_dim(n);
      while (planned < target) begin
         choice = $urandom_range(99);
         if (choice < 70) begin
            repeat ($urandom_range(4)) begin
               if ($urandom_range(1))
                  queue_item(mme_pkg::OP_LOAD_LEFT, $urandom_range(mm - 1),
                             $urandom_range(kk - 1), pick_value());
               else
                  queue_item(mme_pkg::OP_LOAD_RIGHT, $urandom_range(kk - 1),
                             $urandom_range(nn - 1), pick_value());
            end
            queue_compute();
         end else if (choice < 88) begin
            queue_item($urandom_range(1) ? mme_pkg::OP_LOAD_RIGHT : mme_pkg::OP_LOAD_LEFT,
                       $urandom_range(7), $urandom_range(7), pick_value());
         end else begin
            queue_item(OP_UNUSED, $urandom_range(7), $urandom_range(7),
                       mme_pkg::ELEM_W'($urandom));
         end
      end
      wait_quiet();
   endtask

   // Stimulus: directed corners, then random phases at several dimensions
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Zero rows act as one, three inner terms, two columns
      set_dims(4'd0, 4'd3, 4'd2);
      idle_pct = 0;
      queue_item(mme_pkg::OP_LOAD_LEFT, 0, 0, 16'h8000);
      queue_item(mme_pkg::OP_LOAD_LEFT, 0, 1, 16'h8000);
      queue_item(mme_pkg::OP_LOAD_LEFT, 0, 2, 16'h8000);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 0, 0, 16'h8000);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 1, 0, 16'h8000);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 2, 0, 16'h8000);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 0, 1, 16'h7FFF);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 1, 1, 16'h7FFF);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 2, 1, 16'h7FFF);
      // Sums beyond both Q16.16 limits: saturate high and low
      queue_item(mme_pkg::OP_COMPUTE, 0, 0, 16'h0000);
      queue_item(OP_UNUSED, 7, 7, 16'h7FFF);
      queue_item(mme_pkg::OP_LOAD_LEFT, 7, 7, 16'h7FFF);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 7, 7, 16'h8000);
      // Zero, one and the smallest step: in-range sums
      queue_item(mme_pkg::OP_LOAD_LEFT, 0, 1, 16'h0000);
      queue_item(mme_pkg::OP_LOAD_LEFT, 0, 2, 16'h0100);
      queue_item(mme_pkg::OP_LOAD_RIGHT, 1, 1, 16'h0001);
      queue_item(mme_pkg::OP_COMPUTE, 7, 7, 16'hFFFF);
      wait_quiet();

      run_phase(mme_pkg::DIM_W'($urandom_range(1, 4)), mme_pkg::DIM_W'($urandom_range(1, 4)),
                mme_pkg::DIM_W'($urandom_range(1, 4)), 0, 20);
      run_phase(4'd8, 4'd8, 4'd8, 59, 60);
      run_phase(mme_pkg::DIM_W'($urandom_range(1, 4)), mme_pkg::DIM_W'($urandom_range(1, 4)),
                mme_pkg::DIM_W'($urandom_range(1, 4)), 0, 15);
      run_phase(4'd1, 4'd15, 4'd0, 29, 15);
      run_phase(mme_pkg::DIM_W'($urandom_range(0, 5)), mme_pkg::DIM_W'($urandom_range(0, 5)),
                mme_pkg::DIM_W'($urandom_range(0, 5)), 59, 20);

      repeat (20) @(posedge clock);
      if (expected_elems.size() != 0) begin
         $display("%0d expected results never arrived", expected_elems.size());
         errors += expected_elems.size();
      end

      $display("Ran %0d command transactions (%0d computes) over six dimension settings;",
               cmds_accepted, computes_run);
      $display("checked %0d result elements, %0d errors.", elems_checked, errors);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
